/* design/sicp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicp_pkg: shared types and constants for the sine/cosine polynomial unit
// Working format is signed Q40 held in 48 bits; tables are reciprocal
// factorials rounded to the nearest Q40 value.
// ----------------------------------------------------------------------------
package sicp_pkg;

    localparam int WORK_W    = 48;
    localparam int HALF_W    = 24;
    localparam int WORK_FRAC = 40;
    localparam int MAX_TERMS = 12;

    typedef logic signed [WORK_W-1:0] t_work;

    // 1/(2*pi) in Q0.32, kept positive in a signed word
    localparam logic signed [32:0] INV_TWO_PI_Q32 = 33'sh0_28BE_60DC;
    // 2*pi in Q40
    localparam t_work TWO_PI_Q40 = 48'sh0648_7ED5_110B;

    // odd series: (-1)^k / (2k+1)!
    localparam t_work SIN_COEF [MAX_TERMS] = '{
        48'sd1099511627776, -48'sd183251937963, 48'sd9162596898, -48'sd218157069,
        48'sd3029959, -48'sd27545, 48'sd177, -48'sd1,
        48'sd0, 48'sd0, 48'sd0, 48'sd0
    };

    // even series: (-1)^k / (2k)!
    localparam t_work COS_COEF [MAX_TERMS] = '{
        48'sd1099511627776, -48'sd549755813888, 48'sd45812984491, -48'sd1527099483,
        48'sd27269634, -48'sd302996, 48'sd2295, -48'sd13,
        48'sd0, 48'sd0, 48'sd0, 48'sd0
    };

    // latency of one fixed-point multiply-add
    localparam int MUL_LAT = 4;

endpackage

/* design/sin_cos_polynomial_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sin_cos_polynomial_unit: sine and cosine of a fixed-point angle
// Each Horner step is one 4-stage multiplier.
// Throughput: one transaction per cycle while the skid stage is empty; every
//   stage is registered and the output is parted from the pipeline by an
//   output register and a skid stage.
// Reset: synchronous, active low; clears valid bits and skid state only.
// ----------------------------------------------------------------------------
// Flow:
//   S1  a * 1/(2*pi)                      (32x33 multiply)
//   S2  n = floor(product + 1/2)          (add, arithmetic shift)
//   S3  n * 2*pi in Q40                   (narrow-by-constant multiply)
//   S4  r = a - n*2*pi, Q40               (wide subtract)
//   r^2, then SERIES_TERMS-1 Horner steps for both series in parallel,
//   then r * odd sum for sine while cosine waits in a delay line,
//   then two stages of Q40 -> Q30 rounding and saturation.
// The whole pipeline advances together; it holds only while the skid stage
// is occupied, so an input transaction is still taken while a finished
// result waits at the output.
// ----------------------------------------------------------------------------
module sin_cos_polynomial_unit #(
    parameter int SERIES_TERMS    = 12,   // 6 .. 12
    parameter int ANGLE_FRAC_BITS = 24    // 16 .. 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] angle (signed)

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [31:0] sine, [63:32] cosine (signed)
);

    localparam int W     = sicp_pkg::WORK_W;
    localparam int T     = SERIES_TERMS;
    localparam int LAT   = sicp_pkg::MUL_LAT;
    localparam int NW    = 34 - ANGLE_FRAC_BITS;    // turn count width, signed
    localparam int PIPE  = 4 * T + 10;              // pipeline register stages
    localparam int RDLY  = 4 * T;                   // r waits for the odd sum
    localparam int R2DLY = 4 * (T - 2);             // r^2 tap line for Horner

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic w_en;          // whole pipeline advances
    logic w_accept;
    logic w_take;
    logic r_skid_valid;  // a finished result parked behind the output register

    logic [PIPE-1:0] r_vld;

    assign w_en            = ~r_skid_valid;
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE-2:0], w_accept};
        end
    end

    // ------------------------------------------------------------------
    // Range reduction
    // ------------------------------------------------------------------
    logic signed [63:0]   r_s1_prod;
    logic signed [31:0]   r_s1_a;
    logic signed [63:0]   w_s2_sum;
    logic signed [NW-1:0] r_s2_n;
    logic signed [31:0]   r_s2_a;
    logic signed [63:0]   r_s3_np;
    logic signed [31:0]   r_s3_a;
    logic signed [63:0]   w_s4_full;
    sicp_pkg::t_work      r_s4_r;

    assign w_s2_sum  = r_s1_prod + (64'sd1 <<< (ANGLE_FRAC_BITS + 31));
    assign w_s4_full = (64'(r_s3_a) <<< (sicp_pkg::WORK_FRAC - ANGLE_FRAC_BITS))
                     - r_s3_np;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_prod <= $signed(i_s_axis_tdata) * sicp_pkg::INV_TWO_PI_Q32;
            r_s1_a    <= $signed(i_s_axis_tdata);
            r_s2_n    <= NW'(w_s2_sum >>> (ANGLE_FRAC_BITS + 32));
            r_s2_a    <= r_s1_a;
            r_s3_np   <= r_s2_n * sicp_pkg::TWO_PI_Q40;
            r_s3_a    <= r_s2_a;
            r_s4_r    <= w_s4_full[W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // r^2 and delay lines for r and r^2
    // ------------------------------------------------------------------
    sicp_pkg::t_work w_r2;
    sicp_pkg::t_work r_rdly  [RDLY];
    sicp_pkg::t_work r_r2dly [R2DLY];

    sicp_mul_q40 u_mul_r2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_s4_r),
        .i_b   (r_s4_r),
        .i_c   ('0),
        .o_p   (w_r2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rdly[0]  <= r_s4_r;
            r_r2dly[0] <= w_r2;
            for (int k = 1; k < RDLY; k++) begin
                r_rdly[k] <= r_rdly[k-1];
            end
            for (int k = 1; k < R2DLY; k++) begin
                r_r2dly[k] <= r_r2dly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner chains: step j folds in coefficient T-2-j
    // ------------------------------------------------------------------
    sicp_pkg::t_work w_hs [T];
    sicp_pkg::t_work w_hc [T];

    assign w_hs[0] = sicp_pkg::SIN_COEF[T-1];
    assign w_hc[0] = sicp_pkg::COS_COEF[T-1];

    for (genvar j = 0; j < T - 1; j++) begin : g_horner
        sicp_pkg::t_work w_r2_tap;

        if (j == 0) begin : g_first
            assign w_r2_tap = w_r2;
        end else begin : g_later
            assign w_r2_tap = r_r2dly[LAT*j - 1];
        end

        sicp_mul_q40 u_mul_sin (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_hs[j]),
            .i_b   (w_r2_tap),
            .i_c   (sicp_pkg::SIN_COEF[T-2-j]),
            .o_p   (w_hs[j+1])
        );

        sicp_mul_q40 u_mul_cos (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_hc[j]),
            .i_b   (w_r2_tap),
            .i_c   (sicp_pkg::COS_COEF[T-2-j]),
            .o_p   (w_hc[j+1])
        );
    end

    // ------------------------------------------------------------------
    // sine = r * odd sum; cosine held alongside
    // ------------------------------------------------------------------
    sicp_pkg::t_work w_sin_q40;
    sicp_pkg::t_work r_cdly [LAT];

    sicp_mul_q40 u_mul_final (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_rdly[RDLY-1]),
        .i_b   (w_hs[T-1]),
        .i_c   ('0),
        .o_p   (w_sin_q40)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cdly[0] <= w_hc[T-1];
            for (int k = 1; k < LAT; k++) begin
                r_cdly[k] <= r_cdly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Q40 -> Q30: round half away from zero, then saturate to +-1
    // ------------------------------------------------------------------
    function automatic logic [W:0] round_mag(input sicp_pkg::t_work v);
        logic [W:0] m;
        m = v[W-1] ? ({1'b0, ~v} + (W+1)'(513)) : ({1'b0, v} + (W+1)'(512));
        return m;
    endfunction

    function automatic logic [31:0] sat_sign(input logic [W-10:0] m, input logic neg);
        logic [31:0] s;
        s = (m > (W-9)'(32'h4000_0000)) ? 32'h4000_0000 : 32'(m);
        return neg ? (~s + 32'd1) : s;
    endfunction

    logic [W:0]    w_sin_rm;
    logic [W:0]    w_cos_rm;
    logic [W-10:0] r_x_sin_m;
    logic [W-10:0] r_x_cos_m;
    logic          r_x_sin_neg;
    logic          r_x_cos_neg;
    logic [31:0]   r_y_sin;
    logic [31:0]   r_y_cos;

    assign w_sin_rm = round_mag(w_sin_q40);
    assign w_cos_rm = round_mag(r_cdly[LAT-1]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_sin_m   <= w_sin_rm[W:10];
            r_x_cos_m   <= w_cos_rm[W:10];
            r_x_sin_neg <= w_sin_q40[W-1];
            r_x_cos_neg <= r_cdly[LAT-1][W-1];
            r_y_sin     <= sat_sign(r_x_sin_m, r_x_sin_neg);
            r_y_cos     <= sat_sign(r_x_cos_m, r_x_cos_neg);
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    logic        w_incoming;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [63:0] r_skid_data;

    assign w_incoming = w_en & r_vld[PIPE-1];
    assign w_take     = r_out_valid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_incoming;
            end
        end else if (w_incoming) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out_data <= r_skid_valid ? r_skid_data : {r_y_cos, r_y_sin};
        end else if (w_incoming) begin
            r_skid_data <= {r_y_cos, r_y_sin};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* design/sicp_mul_q40.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicp_mul_q40: pipelined Q40 x Q40 multiply with constant addend
// p = round(a*b) + c, rounding to nearest with ties away from zero on the
// magnitude. Four stages, all advancing on i_en.
// ----------------------------------------------------------------------------
module sicp_mul_q40 (
    input  logic             i_clk,
    input  logic             i_en,
    input  sicp_pkg::t_work  i_a,
    input  sicp_pkg::t_work  i_b,
    input  sicp_pkg::t_work  i_c,   // constant addend, applied in the last stage
    output sicp_pkg::t_work  o_p
);

    localparam int W  = sicp_pkg::WORK_W;
    localparam int H  = sicp_pkg::HALF_W;
    localparam int FW = 2 * W;

    logic [W-1:0]  w_ma;
    logic [W-1:0]  w_mb;
    logic [FW-1:0] w_sum;
    logic [W-1:0]  w_sgn;

    // stage A: magnitudes and sign
    logic [W-1:0]  r_ma;
    logic [W-1:0]  r_mb;
    logic          r_neg_a;
    // stage B: partial products
    logic [W-1:0]  r_ll;
    logic [W-1:0]  r_lh;
    logic [W-1:0]  r_hl;
    logic [W-1:0]  r_hh;
    logic          r_neg_b;
    // stage C: rounded magnitude
    logic [W-1:0]  r_m;
    logic          r_neg_c;
    // stage D: signed result plus addend
    sicp_pkg::t_work r_p;

    assign w_ma = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign w_mb = i_b[W-1] ? (~i_b + W'(1)) : i_b;

    assign w_sum = {{W{1'b0}}, r_ll}
                 + ({{W{1'b0}}, r_lh} << H)
                 + ({{W{1'b0}}, r_hl} << H)
                 + {r_hh, {W{1'b0}}}
                 + (FW'(1) << (sicp_pkg::WORK_FRAC - 1));

    assign w_sgn = r_neg_c ? (~r_m + W'(1)) : r_m;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma    <= w_ma;
            r_mb    <= w_mb;
            r_neg_a <= i_a[W-1] ^ i_b[W-1];

            r_ll    <= r_ma[H-1:0] * r_mb[H-1:0];
            r_lh    <= r_ma[H-1:0] * r_mb[W-1:H];
            r_hl    <= r_ma[W-1:H] * r_mb[H-1:0];
            r_hh    <= r_ma[W-1:H] * r_mb[W-1:H];
            r_neg_b <= r_neg_a;

            r_m     <= w_sum[sicp_pkg::WORK_FRAC +: W];
            r_neg_c <= r_neg_b;

            r_p     <= sicp_pkg::t_work'(w_sgn + i_c);
        end
    end

    assign o_p = r_p;

endmodule
